/* design/pp_pkg.sv */
// Shared types, constants and helper functions of the particle pool engine.
package pp_pkg;

    localparam int CAPACITY = 256;
    localparam int SLOT_W   = 8;
    localparam int CNT_W    = 9;
    localparam int VAL_W    = 24;
    localparam int E_W      = 17;
    localparam int NUM_W    = 40;
    localparam int ACC_W    = 64;
    localparam int MA_W     = 27;
    localparam int MB_W     = 18;
    localparam int LAST_CH  = 4;
    localparam int G_NOMINAL = 980;

    typedef enum logic [1:0] {
        FN_SPAWN = 2'd0,
        FN_TICK  = 2'd1,
        FN_READ  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_DEAD = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CFG_COLOR_START = 3'd0,
        CFG_COLOR_END   = 3'd1,
        CFG_SIZE_START  = 3'd2,
        CFG_SIZE_END    = 3'd3,
        CFG_GRAVITY     = 3'd4,
        CFG_DRAG        = 3'd5
    } cfg_index_t;

    typedef enum logic [4:0] {
        S_IDLE, S_SP_CHK, S_SP_WR,
        S_TK_G0, S_TK_D0, S_TK_D1, S_TK_G1, S_TK_G2, S_TK_FG,
        S_TK_SLOT, S_TK_WAIT, S_TK_VX1, S_TK_VY0, S_TK_VY1, S_TK_VYG,
        S_TK_PX1, S_TK_PY0, S_TK_PY1, S_TK_WB, S_TK_END,
        S_RD_CHK, S_RD_WAIT, S_RD_DIV, S_LP0, S_LP1, S_LP2,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [VAL_W-1:0] px;
        logic [VAL_W-1:0] py;
        logic [VAL_W-1:0] vx;
        logic [VAL_W-1:0] vy;
        logic [VAL_W-1:0] left;
        logic [VAL_W-1:0] full;
    } particle_t;

    typedef struct packed {
        logic pos;
        logic vel;
        logic left;
        logic full;
    } store_we_t;

    typedef struct packed {
        logic en;
        logic clr;
        logic hi;
    } mac_ctl_t;

    typedef struct packed {
        logic [1:0]       func;
        logic [VAL_W-1:0] pos_x;
        logic [VAL_W-1:0] pos_y;
        logic [VAL_W-1:0] vel_x;
        logic [VAL_W-1:0] vel_y;
        logic [VAL_W-1:0] lifetime;
        logic [VAL_W-1:0] delta;
        logic [7:0]       slot;
    } in_t;

    typedef struct packed {
        status_t          status;
        logic [7:0]       slot_used;
        logic [VAL_W-1:0] x;
        logic [VAL_W-1:0] y;
        logic [15:0]      size;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
    } res_t;

    // Clamp to the signed 24-bit range.
    function automatic logic [VAL_W-1:0] sat24(input logic signed [ACC_W-1:0] x);
        logic [VAL_W-1:0] r;
        if (x > 64'sd8388607) begin
            r = 24'h7FFFFF;
        end else if (x < -64'sd8388608) begin
            r = 24'h800000;
        end else begin
            r = x[VAL_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] sext24(input logic [VAL_W-1:0] v);
        return $signed({{(ACC_W-VAL_W){v[VAL_W-1]}}, v});
    endfunction

endpackage

/* design/pp_store.sv */
// Particle state memories: position, velocity and life, one entry per slot.
module pp_store
    import pp_pkg::*;
(
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output particle_t         rd_data,
    input  store_we_t         we,
    input  logic [SLOT_W-1:0] wr_addr,
    input  particle_t         wr_data
);

    logic [VAL_W-1:0] px_mem   [CAPACITY];
    logic [VAL_W-1:0] py_mem   [CAPACITY];
    logic [VAL_W-1:0] vx_mem   [CAPACITY];
    logic [VAL_W-1:0] vy_mem   [CAPACITY];
    logic [VAL_W-1:0] left_mem [CAPACITY];
    logic [VAL_W-1:0] full_mem [CAPACITY];
    particle_t        rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we.pos) begin
            px_mem[wr_addr] <= wr_data.px;
            py_mem[wr_addr] <= wr_data.py;
        end
        if (we.vel) begin
            vx_mem[wr_addr] <= wr_data.vx;
            vy_mem[wr_addr] <= wr_data.vy;
        end
        if (we.left) begin
            left_mem[wr_addr] <= wr_data.left;
        end
        if (we.full) begin
            full_mem[wr_addr] <= wr_data.full;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg.px   <= px_mem[rd_addr];
            rd_data_reg.py   <= py_mem[rd_addr];
            rd_data_reg.vx   <= vx_mem[rd_addr];
            rd_data_reg.vy   <= vy_mem[rd_addr];
            rd_data_reg.left <= left_mem[rd_addr];
            rd_data_reg.full <= full_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/pp_free.sv */
// Free-slot stack memory; entries never pushed read as their reset contents.
module pp_free
    import pp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic [SLOT_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  logic [SLOT_W-1:0] wr_data
);

    logic [SLOT_W-1:0]   mem [CAPACITY];
    logic [CAPACITY-1:0] valid_reg;
    logic [SLOT_W-1:0]   rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            // After reset the stack holds descending indices, slot 0 on top.
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr]
                                              : SLOT_W'(CAPACITY - 1 - int'(rd_addr));
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/pp_mac.sv */
// Shared multiply-accumulate unit; wide products are built from two chunks.
module pp_mac
    import pp_pkg::*;
(
    input  logic                    aclk,
    input  mac_ctl_t                ctl,
    input  logic signed [MA_W-1:0]  a,
    input  logic signed [MB_W-1:0]  b,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [MA_W+MB_W-1:0] prod;
    logic signed [ACC_W-1:0]     term;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ACC_W-1:0]     acc_next;

    always_comb begin
        prod = a * b;
        term = $signed({{(ACC_W-MA_W-MB_W){prod[MA_W+MB_W-1]}}, prod});
        if (ctl.hi) begin
            // Upper chunk of the wide operand carries weight 2^17.
            term = term <<< (MB_W - 1);
        end
        acc_next = (ctl.clr ? '0 : acc_reg) + term;
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

/* design/pp_div.sv */
// Serial restoring divider for the elapsed-life fraction, one bit a cycle.
module pp_div
    import pp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [VAL_W-1:0] den,
    output logic             done,
    output logic [E_W-1:0]   q
);

    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [VAL_W-1:0] rem_reg, rem_next;
    logic [VAL_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [E_W-1:0]   q_reg, q_next;
    logic [VAL_W:0]   trial;
    logic [VAL_W:0]   diff;
    logic             ge;

    always_comb begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        ge        = trial >= {1'b0, den_reg};
        diff      = trial - {1'b0, den_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        if (start) begin
            cnt_next  = 6'(NUM_W);
            busy_next = 1'b1;
            rem_next  = '0;
            den_next  = den;
            num_next  = num;
        end else if (busy_reg) begin
            rem_next = ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            q_next   = {q_reg[E_W-2:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        num_reg <= num_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

/* design/particle_pool_engine.sv */
// Top level of the particle pool engine: stream ports, sequencer and register file.
// The engine keeps a pool of 256 particles and takes one command beat at a time
// on the s_ side, returning exactly one result beat per command on the m_ side.
// s_tuser selects the command: spawn, tick or read slot. Every product goes
// through a single shared 27x18 multiply-accumulate unit driven by a small
// sequencer, so the block is busy while it works on a command and holds
// s_tready low meanwhile; a finished result waits in the output register, so
// the next command is taken while the previous result is still unread. A spawn
// pops the free-slot stack unless the pool is full, a read of a dead slot or an
// unknown command is answered without further work, a read of a live slot runs
// the serial divider that forms the elapsed-life fraction (one quotient bit per
// cycle) and then interpolates size and colour, and a tick walks the slots below
// the high-water mark, each slot that lives on taking eight passes through the
// multiplier. The particle state sits in memories with a separate read and
// write port; the free-slot stack uses per-entry valid bits, so no clearing
// pass follows reset. Configuration writes on cfg_wr_en are taken in any cycle
// and must only be issued while the engine is idle.
module particle_pool_engine
    import pp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, vel_x, vel_y, lifetime, delta, slot
    input  logic [151:0] s_tdata,
    // func
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot_used, alive_total, out_x, out_y, out_size, red, green, blue, alpha, pad
    output logic [119:0] m_tdata,
    // status
    output logic [1:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wr_data
);

    state_t              state_reg, state_next;
    in_t                 in_reg, in_next;
    res_t                res_reg, res_next;
    logic [CAPACITY-1:0] alive_reg, alive_next;
    logic [CNT_W-1:0]    free_count_reg, free_count_next;
    logic [CNT_W-1:0]    high_water_reg, high_water_next;
    logic [CNT_W-1:0]    alive_count_reg, alive_count_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    na_reg, na_next;
    logic [CNT_W-1:0]    nhw_reg, nhw_next;
    logic signed [33:0]  f_reg, f_next;
    logic signed [34:0]  g_reg, g_next;
    logic signed [MA_W-1:0] gs980_reg, gs980_next;
    logic [VAL_W-1:0]    vx_new_reg, vx_new_next;
    logic [VAL_W-1:0]    vy_new_reg, vy_new_next;
    logic [VAL_W-1:0]    px_new_reg, px_new_next;
    logic [VAL_W-1:0]    left_new_reg, left_new_next;
    logic [E_W-1:0]      e_reg, e_next;
    logic [2:0]          ch_reg, ch_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [119:0]        m_tdata_reg, m_tdata_next;
    logic [1:0]          m_tuser_reg, m_tuser_next;

    logic [31:0] color_start_reg, color_end_reg;
    logic [15:0] size_start_reg, size_end_reg, gravity_reg, drag_reg;

    logic              st_rd_en;
    logic [SLOT_W-1:0] st_rd_addr;
    particle_t         st_rd;
    store_we_t         st_we;
    logic [SLOT_W-1:0] st_wr_addr;
    particle_t         st_wr;

    logic              fr_rd_en;
    logic [SLOT_W-1:0] fr_rd_data;
    logic              fr_wr_en;

    mac_ctl_t               mac_ctl;
    logic signed [MA_W-1:0] mac_a;
    logic signed [MB_W-1:0] mac_b;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_sh;

    logic             div_start;
    logic             div_done;
    logic [E_W-1:0]   div_q;
    logic [NUM_W-1:0] div_num;

    logic signed [MB_W-1:0] d_lo, d_hi, f_lo, f_hi;
    logic [15:0]            lerp_start, lerp_end;
    logic [VAL_W-1:0]       vy_drag;
    logic [VAL_W-1:0]       life_diff;

    pp_store u_store (
        .aclk    (aclk),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd),
        .we      (st_we),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr)
    );

    pp_free u_free (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (fr_rd_en),
        .rd_addr (SLOT_W'(free_count_reg - CNT_W'(1))),
        .rd_data (fr_rd_data),
        .wr_en   (fr_wr_en),
        .wr_addr (free_count_reg[SLOT_W-1:0]),
        .wr_data (idx_reg[SLOT_W-1:0])
    );

    pp_mac u_mac (
        .aclk (aclk),
        .ctl  (mac_ctl),
        .a    (mac_a),
        .b    (mac_b),
        .acc  (acc)
    );

    pp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (st_rd.full),
        .done    (div_done),
        .q       (div_q)
    );

    // Configuration register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_start_reg <= 32'hFFFFFFFF;
            color_end_reg   <= 32'hFFFFFF00;
            size_start_reg  <= 16'd2048;
            size_end_reg    <= 16'd512;
            gravity_reg     <= 16'd0;
            drag_reg        <= 16'd256;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_COLOR_START: color_start_reg <= cfg_wr_data;
                CFG_COLOR_END:   color_end_reg   <= cfg_wr_data;
                CFG_SIZE_START:  size_start_reg  <= cfg_wr_data[15:0];
                CFG_SIZE_END:    size_end_reg    <= cfg_wr_data[15:0];
                CFG_GRAVITY:     gravity_reg     <= cfg_wr_data[15:0];
                CFG_DRAG:        drag_reg        <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    // Operand chunks: the wide multiplicand is split into a 17-bit low part and
    // a high part weighted by 2^17.
    assign d_lo = $signed({1'b0, in_reg.delta[16:0]});
    assign d_hi = $signed({11'b0, in_reg.delta[23:17]});
    assign f_lo = $signed({1'b0, f_reg[16:0]});
    assign f_hi = $signed({f_reg[33], f_reg[33:17]});
    assign acc_sh    = acc >>> 16;
    assign life_diff = st_rd.full - st_rd.left;
    assign div_num   = {life_diff, 16'b0};

    always_comb begin
        case (ch_reg)
            3'd0:    begin lerp_start = size_start_reg;
                           lerp_end   = size_end_reg; end
            3'd1:    begin lerp_start = {8'b0, color_start_reg[31:24]};
                           lerp_end   = {8'b0, color_end_reg[31:24]}; end
            3'd2:    begin lerp_start = {8'b0, color_start_reg[23:16]};
                           lerp_end   = {8'b0, color_end_reg[23:16]}; end
            3'd3:    begin lerp_start = {8'b0, color_start_reg[15:8]};
                           lerp_end   = {8'b0, color_end_reg[15:8]}; end
            default: begin lerp_start = {8'b0, color_start_reg[7:0]};
                           lerp_end   = {8'b0, color_end_reg[7:0]}; end
        endcase
    end

    always_comb begin
        state_next       = state_reg;
        in_next          = in_reg;
        res_next         = res_reg;
        alive_next       = alive_reg;
        free_count_next  = free_count_reg;
        high_water_next  = high_water_reg;
        alive_count_next = alive_count_reg;
        idx_next         = idx_reg;
        na_next          = na_reg;
        nhw_next         = nhw_reg;
        f_next           = f_reg;
        g_next           = g_reg;
        gs980_next       = gs980_reg;
        vx_new_next      = vx_new_reg;
        vy_new_next      = vy_new_reg;
        px_new_next      = px_new_reg;
        left_new_next    = left_new_reg;
        e_next           = e_reg;
        ch_next          = ch_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        s_tready         = 1'b0;
        st_rd_en         = 1'b0;
        st_rd_addr       = idx_reg[SLOT_W-1:0];
        st_we            = '0;
        st_wr_addr       = idx_reg[SLOT_W-1:0];
        st_wr            = '{px: px_new_reg, py: sat24(sext24(st_rd.py) + acc_sh),
                             vx: vx_new_reg, vy: vy_new_reg,
                             left: left_new_reg, full: in_reg.lifetime};
        fr_rd_en         = 1'b0;
        fr_wr_en         = 1'b0;
        mac_ctl          = '0;
        mac_a            = '0;
        mac_b            = '0;
        div_start        = 1'b0;
        vy_drag          = sat24(acc_sh);

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    in_next  = {s_tuser, s_tdata[23:0], s_tdata[47:24], s_tdata[71:48],
                                s_tdata[95:72], s_tdata[119:96], s_tdata[143:120],
                                s_tdata[151:144]};
                    res_next = '0;
                    case (s_tuser)
                        FN_SPAWN: state_next = S_SP_CHK;
                        FN_TICK:  state_next = S_TK_G0;
                        FN_READ:  state_next = S_RD_CHK;
                        default:  state_next = S_DONE;
                    endcase
                end
            end

            // Spawn: pop the top of the free stack, then fill the slot.
            S_SP_CHK: begin
                if (free_count_reg == '0) begin
                    res_next.status = ST_FULL;
                    state_next      = S_DONE;
                end else begin
                    fr_rd_en   = 1'b1;
                    state_next = S_SP_WR;
                end
            end
            S_SP_WR: begin
                st_we      = '{pos: 1'b1, vel: 1'b1, left: 1'b1, full: 1'b1};
                st_wr_addr = fr_rd_data;
                st_wr      = '{px: in_reg.pos_x, py: in_reg.pos_y, vx: in_reg.vel_x,
                               vy: in_reg.vel_y, left: in_reg.lifetime,
                               full: in_reg.lifetime};
                alive_next[fr_rd_data] = 1'b1;
                if ({1'b0, fr_rd_data} >= high_water_reg) begin
                    high_water_next = {1'b0, fr_rd_data} + CNT_W'(1);
                end
                alive_count_next   = alive_count_reg + CNT_W'(1);
                free_count_next    = free_count_reg - CNT_W'(1);
                res_next.slot_used = fr_rd_data;
                state_next         = S_DONE;
            end

            // Tick set-up: gravity step and drag factor, shared by every slot.
            S_TK_G0: begin
                mac_ctl    = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
                mac_a      = $signed({{(MA_W-16){gravity_reg[15]}}, gravity_reg});
                mac_b      = MB_W'(G_NOMINAL);
                idx_next   = '0;
                na_next    = '0;
                nhw_next   = '0;
                state_next = S_TK_D0;
            end
            S_TK_D0: begin
                gs980_next = acc[MA_W-1:0];
                mac_ctl    = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
                mac_a      = $signed({{(MA_W-16){1'b0}}, drag_reg});
                mac_b      = d_lo;
                state_next = S_TK_D1;
            end
            S_TK_D1: begin
                mac_ctl    = '{en: 1'b1, clr: 1'b0, hi: 1'b1};
                mac_a      = $signed({{(MA_W-16){1'b0}}, drag_reg});
                mac_b      = d_hi;
                state_next = S_TK_G1;
            end
            S_TK_G1: begin
                f_next     = 34'sd65536 - $signed({2'b0, acc[39:8]});
                mac_ctl    = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
                mac_a      = gs980_reg;
                mac_b      = d_lo;
                state_next = S_TK_G2;
            end
            S_TK_G2: begin
                mac_ctl    = '{en: 1'b1, clr: 1'b0, hi: 1'b1};
                mac_a      = gs980_reg;
                mac_b      = d_hi;
                state_next = S_TK_FG;
            end
            S_TK_FG: begin
                g_next     = acc_sh[34:0];
                state_next = S_TK_SLOT;
            end

            // Walk the slots below the high-water mark in rising order.
            S_TK_SLOT: begin
                if (idx_reg >= high_water_reg) begin
                    state_next = S_TK_END;
                end else if (!alive_reg[idx_reg[SLOT_W-1:0]]) begin
                    idx_next = idx_reg + CNT_W'(1);
                end else begin
                    st_rd_en   = 1'b1;
                    state_next = S_TK_WAIT;
                end
            end
            S_TK_WAIT: begin
                if (st_rd.left <= in_reg.delta) begin
                    alive_next[idx_reg[SLOT_W-1:0]] = 1'b0;
                    fr_wr_en        = 1'b1;
                    free_count_next = free_count_reg + CNT_W'(1);
                    idx_next        = idx_reg + CNT_W'(1);
                    state_next      = S_TK_SLOT;
                end else begin
                    left_new_next = st_rd.left - in_reg.delta;
                    mac_ctl       = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
                    mac_a         = $signed({{(MA_W-VAL_W){st_rd.vx[VAL_W-1]}}, st_rd.vx});
                    mac_b         = f_lo;
                    state_next    = S_TK_VX1;
                end
            end
            S_TK_VX1: begin
                mac_ctl    = '{en: 1'b1, clr: 1'b0, hi: 1'b1};
                mac_a      = $signed({{(MA_W-VAL_W){st_rd.vx[VAL_W-1]}}, st_rd.vx});
                mac_b      = f_hi;
                state_next = S_TK_VY0;
            end
            S_TK_VY0: begin
                vx_new_next = sat24(acc_sh);
                mac_ctl     = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
                mac_a       = $signed({{(MA_W-VAL_W){st_rd.vy[VAL_W-1]}}, st_rd.vy});
                mac_b       = f_lo;
                state_next  = S_TK_VY1;
            end
            S_TK_VY1: begin
                mac_ctl    = '{en: 1'b1, clr: 1'b0, hi: 1'b1};
                mac_a      = $signed({{(MA_W-VAL_W){st_rd.vy[VAL_W-1]}}, st_rd.vy});
                mac_b      = f_hi;
                state_next = S_TK_VYG;
            end
            S_TK_VYG: begin
                // Drag first, then gravity, each clamped on its own.
                vy_new_next = sat24(sext24(vy_drag)
                                    + $signed({{(ACC_W-35){g_reg[34]}}, g_reg}));
                mac_ctl     = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
                mac_a       = $signed({{(MA_W-VAL_W){vx_new_reg[VAL_W-1]}}, vx_new_reg});
                mac_b       = d_lo;
                state_next  = S_TK_PX1;
            end
            S_TK_PX1: begin
                mac_ctl    = '{en: 1'b1, clr: 1'b0, hi: 1'b1};
                mac_a      = $signed({{(MA_W-VAL_W){vx_new_reg[VAL_W-1]}}, vx_new_reg});
                mac_b      = d_hi;
                state_next = S_TK_PY0;
            end
            S_TK_PY0: begin
                px_new_next = sat24(sext24(st_rd.px) + acc_sh);
                mac_ctl     = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
                mac_a       = $signed({{(MA_W-VAL_W){vy_new_reg[VAL_W-1]}}, vy_new_reg});
                mac_b       = d_lo;
                state_next  = S_TK_PY1;
            end
            S_TK_PY1: begin
                mac_ctl    = '{en: 1'b1, clr: 1'b0, hi: 1'b1};
                mac_a      = $signed({{(MA_W-VAL_W){vy_new_reg[VAL_W-1]}}, vy_new_reg});
                mac_b      = d_hi;
                state_next = S_TK_WB;
            end
            S_TK_WB: begin
                st_we      = '{pos: 1'b1, vel: 1'b1, left: 1'b1, full: 1'b0};
                na_next    = na_reg + CNT_W'(1);
                nhw_next   = idx_reg + CNT_W'(1);
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_TK_SLOT;
            end
            S_TK_END: begin
                alive_count_next = na_reg;
                high_water_next  = nhw_reg;
                state_next       = S_DONE;
            end

            // Read slot: fetch the entry, form the life fraction, interpolate.
            S_RD_CHK: begin
                res_next.slot_used = in_reg.slot;
                st_rd_addr         = in_reg.slot;
                if (!alive_reg[in_reg.slot]) begin
                    res_next.status = ST_DEAD;
                    state_next      = S_DONE;
                end else begin
                    st_rd_en   = 1'b1;
                    state_next = S_RD_WAIT;
                end
            end
            S_RD_WAIT: begin
                res_next.x = st_rd.px;
                res_next.y = st_rd.py;
                ch_next    = '0;
                if (st_rd.full == '0 || st_rd.left > st_rd.full) begin
                    e_next     = '0;
                    state_next = S_LP0;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_RD_DIV;
                end
            end
            S_RD_DIV: begin
                if (div_done) begin
                    e_next     = div_q;
                    state_next = S_LP0;
                end
            end
            S_LP0: begin
                mac_ctl    = '{en: 1'b1, clr: 1'b1, hi: 1'b0};
                mac_a      = $signed({{(MA_W-16){1'b0}}, lerp_start});
                mac_b      = $signed({1'b0, E_W'(17'h10000 - e_reg)});
                state_next = S_LP1;
            end
            S_LP1: begin
                mac_ctl    = '{en: 1'b1, clr: 1'b0, hi: 1'b0};
                mac_a      = $signed({{(MA_W-16){1'b0}}, lerp_end});
                mac_b      = $signed({1'b0, e_reg});
                state_next = S_LP2;
            end
            S_LP2: begin
                case (ch_reg)
                    3'd0:    res_next.size  = acc[31:16];
                    3'd1:    res_next.red   = acc[23:16];
                    3'd2:    res_next.green = acc[23:16];
                    3'd3:    res_next.blue  = acc[23:16];
                    default: res_next.alpha = acc[23:16];
                endcase
                if (ch_reg == 3'(LAST_CH)) begin
                    state_next = S_DONE;
                end else begin
                    ch_next    = ch_reg + 3'd1;
                    state_next = S_LP0;
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_reg.status;
                    m_tdata_next  = {7'b0, res_reg.alpha, res_reg.blue, res_reg.green,
                                     res_reg.red, res_reg.size, res_reg.y, res_reg.x,
                                     alive_count_reg, res_reg.slot_used};
                    state_next    = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            alive_reg       <= '0;
            free_count_reg  <= CNT_W'(CAPACITY);
            high_water_reg  <= '0;
            alive_count_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            alive_reg       <= alive_next;
            free_count_reg  <= free_count_next;
            high_water_reg  <= high_water_next;
            alive_count_reg <= alive_count_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg       <= in_next;
        res_reg      <= res_next;
        idx_reg      <= idx_next;
        na_reg       <= na_next;
        nhw_reg      <= nhw_next;
        f_reg        <= f_next;
        g_reg        <= g_next;
        gs980_reg    <= gs980_next;
        vx_new_reg   <= vx_new_next;
        vy_new_reg   <= vy_new_next;
        px_new_reg   <= px_new_next;
        left_new_reg <= left_new_next;
        e_reg        <= e_next;
        ch_reg       <= ch_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* design/pp_chk.sv */
// Port-level checker for the particle pool engine, bound to the top level.
module pp_chk
    import pp_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata,
    input logic [1:0]   m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_FULL || m_tuser == ST_DEAD))
        else $error("undefined status code");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[16:8]) <= CAPACITY)
        else $error("alive count beyond pool size");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_FULL |-> 32'(m_tdata[16:8]) == CAPACITY
                                           && m_tdata[7:0] == '0)
        else $error("pool full reported with free slots");

    a_dead: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_DEAD |-> m_tdata[112:17] == '0)
        else $error("dead slot read returned data");

endmodule

bind particle_pool_engine pp_chk u_pp_chk (.*);

/* dv/particle_pool_engine_tb.sv */
// Self-checking stream testbench for the particle pool engine.
`timescale 1ns / 100ps

module particle_pool_engine_tb;
    import pp_pkg::*;

    // Opcode three is outside the defined set; the engine must answer it as a no-op.
    localparam logic [1:0] FN_NONE = 2'd3;
    localparam int IDLE_PCT   = 17;
    localparam int HOLD_LEN   = 600;
    // Slowest gap between beats: a tick over a full pool, plus the long receiver
    // hold-off, taken several times over.
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [1:0]         fn;
        logic signed [23:0] px, py, vx, vy;
        logic [23:0]        life, delta;
        logic [7:0]         slot;
    } command_t;

    typedef struct {
        status_t            status;
        logic [7:0]         slot_used;
        logic [8:0]         alive;
        logic signed [23:0] x, y;
        logic [15:0]        size;
        logic [7:0]         red, green, blue, alpha;
    } answer_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [151:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_wr_data = '0;

    particle_pool_engine DUT (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shadow copy of the engine: appearance registers and particle pool.
    logic [31:0]        sh_col_start, sh_col_end;
    logic [15:0]        sh_size_start, sh_size_end, sh_drag;
    logic signed [15:0] sh_gravity;
    logic               sh_alive [CAPACITY];
    logic signed [23:0] sh_px [CAPACITY], sh_py [CAPACITY];
    logic signed [23:0] sh_vx [CAPACITY], sh_vy [CAPACITY];
    logic [23:0]        sh_left [CAPACITY], sh_full [CAPACITY];
    int                 sh_free [CAPACITY];
    int                 sh_free_cnt, sh_high_water, sh_alive_cnt;

    command_t pending [$];
    answer_t  awaited [$];
    command_t cur_cmd;
    int  errors = 0;
    bit  idle_on = 1'b1;
    int  hold_req = 0, hold_seen = 0, hold_cnt = 0;
    int  n_spawn = 0, n_full = 0, n_tick = 0, n_live_rd = 0, n_dead_rd = 0, n_phases = 0;
    int  quiet = 0;

    function automatic logic signed [23:0] clamp24(longint v);
        if (v > 64'sd8388607) return 24'sh7FFFFF;
        if (v < -64'sd8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    function automatic logic [15:0] blend(longint a, longint b, longint e);
        return 16'((a * (65536 - e) + b * e) >>> 16);
    endfunction

    task automatic enqueue(command_t c);
        pending = {pending, c};
    endtask

    task automatic pool_reset();
        sh_col_start = 32'hFFFFFFFF; sh_col_end = 32'hFFFFFF00;
        sh_size_start = 16'd2048; sh_size_end = 16'd512;
        sh_gravity = '0; sh_drag = 16'd256;
        for (int i = 0; i < CAPACITY; i++) begin
            sh_alive[i] = 1'b0;
            sh_free[i]  = CAPACITY - 1 - i;
        end
        sh_free_cnt = CAPACITY; sh_high_water = 0; sh_alive_cnt = 0;
    endtask

    // Advance every live particle by one Euler step, freeing the expired ones.
    task automatic advance_pool(logic [23:0] dt);
        longint f, g, nvx, nvy;
        int na, nhw;
        na = 0; nhw = 0;
        f = 65536 - ((longint'(sh_drag) * longint'(dt)) >>> 8);
        g = (longint'(sh_gravity) * 980 * longint'(dt)) >>> 16;
        for (int i = 0; i < sh_high_water; i++) begin
            if (!sh_alive[i]) continue;
            if (sh_left[i] <= dt) begin
                sh_alive[i] = 1'b0;
                sh_free[sh_free_cnt++] = i;
                continue;
            end
            sh_left[i] = sh_left[i] - dt;
            nvx = clamp24((longint'(sh_vx[i]) * f) >>> 16);
            nvy = clamp24((longint'(sh_vy[i]) * f) >>> 16);
            nvy = clamp24(nvy + g);
            sh_vx[i] = 24'(nvx);
            sh_vy[i] = 24'(nvy);
            sh_px[i] = clamp24(longint'(sh_px[i]) + ((nvx * longint'(dt)) >>> 16));
            sh_py[i] = clamp24(longint'(sh_py[i]) + ((nvy * longint'(dt)) >>> 16));
            na++;
            nhw = i + 1;
        end
        sh_alive_cnt = na;
        sh_high_water = nhw;
    endtask

    // Apply one accepted command to the shadow pool and queue the answer it owes.
    task automatic predict_answer(command_t c);
        answer_t a;
        int idx;
        longint e;
        a = '{status: ST_OK, default: '0};
        case (c.fn)
            FN_SPAWN: begin
                if (sh_free_cnt == 0) begin
                    a.status = ST_FULL;
                    n_full++;
                end else begin
                    idx = sh_free[--sh_free_cnt];
                    sh_alive[idx] = 1'b1;
                    if (idx >= sh_high_water) sh_high_water = idx + 1;
                    sh_px[idx] = c.px; sh_py[idx] = c.py;
                    sh_vx[idx] = c.vx; sh_vy[idx] = c.vy;
                    sh_full[idx] = c.life; sh_left[idx] = c.life;
                    sh_alive_cnt++;
                    a.slot_used = 8'(idx);
                    n_spawn++;
                end
            end
            FN_TICK: begin
                advance_pool(c.delta);
                n_tick++;
            end
            FN_READ: begin
                a.slot_used = c.slot;
                if (!sh_alive[c.slot]) begin
                    a.status = ST_DEAD;
                    n_dead_rd++;
                end else begin
                    e = 0;
                    if (sh_full[c.slot] != 0)
                        e = (longint'(sh_full[c.slot] - sh_left[c.slot]) << 16)
                            / longint'(sh_full[c.slot]);
                    a.x = sh_px[c.slot];
                    a.y = sh_py[c.slot];
                    a.size  = blend(sh_size_start, sh_size_end, e);
                    a.red   = 8'(blend(sh_col_start[31:24], sh_col_end[31:24], e));
                    a.green = 8'(blend(sh_col_start[23:16], sh_col_end[23:16], e));
                    a.blue  = 8'(blend(sh_col_start[15:8], sh_col_end[15:8], e));
                    a.alpha = 8'(blend(sh_col_start[7:0], sh_col_end[7:0], e));
                    n_live_rd++;
                end
            end
            default: ;
        endcase
        a.alive = 9'(sh_alive_cnt);
        awaited = {awaited, a};
    endtask

    task automatic report(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    // Sender: the current beat is held until taken, then the next one is offered
    // unless this cycle is chosen to idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_answer(cur_cmd);
            if (!s_tvalid || s_tready) begin
                if (pending.size() > 0 && !(idle_on && $urandom_range(99) < IDLE_PCT)) begin
                    cur_cmd = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_cmd.fn;
                    s_tdata  <= {cur_cmd.slot, cur_cmd.delta, cur_cmd.life,
                                 cur_cmd.vy, cur_cmd.vx, cur_cmd.py, cur_cmd.px};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver pacing: random stalls, and a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_cnt  <= HOLD_LEN;
            m_tready  <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Result checker: every beat taken is compared with the oldest expectation.
    always @(posedge aclk) begin
        answer_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited.size() == 0) begin
                report("unexpected result beat", m_tuser, 0);
            end else begin
                w = awaited.pop_front();
                if (m_tuser != w.status) report("status", m_tuser, w.status);
                if (m_tdata[7:0] != w.slot_used) report("slot_used", m_tdata[7:0], w.slot_used);
                if (m_tdata[16:8] != w.alive) report("alive_total", m_tdata[16:8], w.alive);
                if (m_tdata[40:17] != w.x) report("out_x", m_tdata[40:17], w.x);
                if (m_tdata[64:41] != w.y) report("out_y", m_tdata[64:41], w.y);
                if (m_tdata[80:65] != w.size) report("out_size", m_tdata[80:65], w.size);
                if (m_tdata[88:81] != w.red) report("red", m_tdata[88:81], w.red);
                if (m_tdata[96:89] != w.green) report("green", m_tdata[96:89], w.green);
                if (m_tdata[104:97] != w.blue) report("blue", m_tdata[104:97], w.blue);
                if (m_tdata[112:105] != w.alpha) report("alpha", m_tdata[112:105], w.alpha);
            end
        end
    end

    // Watchdog: counts cycles in which neither side moves a beat.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic command_t mk(logic [1:0] fn, logic [23:0] px = 0, logic [23:0] py = 0,
                                    logic [23:0] vx = 0, logic [23:0] vy = 0,
                                    logic [23:0] life = 0, logic [23:0] delta = 0,
                                    logic [7:0] slot = 0);
        command_t c;
        c.fn = fn; c.px = px; c.py = py; c.vx = vx; c.vy = vy;
        c.life = life; c.delta = delta; c.slot = slot;
        return c;
    endfunction

    // A random command. Most are well-formed with modest lifetimes and steps so
    // that particles live through several ticks; a few carry fully random bits.
    function automatic command_t random_cmd();
        command_t c;
        int pick;
        bit wild;
        pick = $urandom_range(99);
        wild = ($urandom_range(9) == 0);
        c = mk(FN_SPAWN, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
               24'(wild ? $urandom : $urandom_range(1, 1 << 18)),
               24'(wild ? $urandom : $urandom_range(0, 1 << 15)),
               8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(40)));
        if (!wild) begin
            c.vx = $signed(c.vx) >>> $urandom_range(12);
            c.vy = $signed(c.vy) >>> $urandom_range(12);
        end
        if (pick < 40)      c.fn = FN_SPAWN;
        else if (pick < 62) c.fn = FN_TICK;
        else if (pick < 96) c.fn = FN_READ;
        else                c.fn = FN_NONE;
        return c;
    endfunction

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending.size() > 0 || s_tvalid || awaited.size() > 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        case (idx)
            CFG_COLOR_START: sh_col_start  = val;
            CFG_COLOR_END:   sh_col_end    = val;
            CFG_SIZE_START:  sh_size_start = val[15:0];
            CFG_SIZE_END:    sh_size_end   = val[15:0];
            CFG_GRAVITY:     sh_gravity    = val[15:0];
            CFG_DRAG:        sh_drag       = val[15:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_appearance(logic [31:0] cs, logic [31:0] ce, logic [15:0] ss,
                                  logic [15:0] se, logic [15:0] grav, logic [15:0] drag);
        write_reg(CFG_COLOR_START, cs);
        write_reg(CFG_COLOR_END, ce);
        write_reg(CFG_SIZE_START, 32'(ss));
        write_reg(CFG_SIZE_END, 32'(se));
        write_reg(CFG_GRAVITY, 32'(grav));
        write_reg(CFG_DRAG, 32'(drag));
        n_phases++;
    endtask

    initial begin
        pool_reset();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed opening under the reset appearance: dead reads at both ends,
        // spawns at the field extremes, zero and full lifetimes, a zero step,
        // the unused opcode, and a huge step that expires everything.
        enqueue(mk(FN_READ, .slot(8'd0)));
        enqueue(mk(FN_READ, .slot(8'd255)));
        enqueue(mk(FN_SPAWN, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
                   24'd1));
        enqueue(mk(FN_SPAWN, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                   24'hFFFFFF));
        enqueue(mk(FN_SPAWN, 24'h000100, 24'hFFFF00, 24'h000000, 24'h000000,
                   24'd0));
        enqueue(mk(FN_SPAWN, 24'h001000, 24'h002000, 24'h000800, 24'hFFF800,
                   24'h020000));
        enqueue(mk(FN_READ, .slot(8'd1)));
        enqueue(mk(FN_READ, .slot(8'd2)));
        enqueue(mk(FN_TICK, .delta(24'd0)));
        enqueue(mk(FN_READ, .slot(8'd0)));
        enqueue(mk(FN_TICK, .delta(24'h004000)));
        enqueue(mk(FN_READ, .slot(8'd1)));
        enqueue(mk(FN_READ, .slot(8'd3)));
        enqueue(mk(FN_NONE, .slot(8'd3)));
        enqueue(mk(FN_SPAWN, 24'h0, 24'h0, 24'h0, 24'h0, 24'h010000));
        enqueue(mk(FN_READ, .slot(8'd2)));
        enqueue(mk(FN_TICK, .delta(24'h8000)));
        enqueue(mk(FN_READ, .slot(8'd1)));
        enqueue(mk(FN_TICK, .delta(24'hFFFFFF)));
        enqueue(mk(FN_READ, .slot(8'd1)));
        wait_idle();

        // Fill the whole pool under the long receiver hold-off, overflow it,
        // walk a full tick, then clear it with the largest step.
        set_appearance(32'h00000000, 32'hFFFFFFFF, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h0000);
        hold_req++;
        for (int i = 0; i < CAPACITY; i++)
            enqueue(mk(FN_SPAWN, 24'($urandom), 24'($urandom), 24'($urandom),
                       24'($urandom), 24'($urandom_range(1 << 20, 24'hFFFFFF))));
        enqueue(mk(FN_SPAWN, .life(24'd5)));
        enqueue(mk(FN_SPAWN, .life(24'd5)));
        enqueue(mk(FN_READ, .slot(8'd255)));
        enqueue(mk(FN_TICK, .delta(24'h000100)));
        enqueue(mk(FN_READ, .slot(8'd128)));
        enqueue(mk(FN_TICK, .delta(24'hFFFFFF)));
        enqueue(mk(FN_READ, .slot(8'd255)));
        wait_idle();

        // Random phases, each under its own appearance, including the corners
        // of gravity and drag. One phase runs with no idling on either side.
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: set_appearance(32'hFFFFFFFF, 32'h00000000, 16'hFFFF, 16'h0000,
                                  16'h8000, 16'hFFFF);
                1: set_appearance(32'h00000000, 32'h00000000, 16'h0000, 16'h0000,
                                  16'h0000, 16'h0000);
                2: set_appearance(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF,
                                  16'h7FFF, 16'hFFFF);
                3: set_appearance(32'h12345678, 32'h87654321, 16'h0800, 16'h0200,
                                  16'hFF00, 16'h0100);
                default: set_appearance($urandom, $urandom, 16'($urandom), 16'($urandom),
                                        16'($urandom), 16'($urandom_range(0, 16'h0400)));
            endcase
            idle_on = (ph != 4);
            if (ph == 6) hold_req++;
            for (int k = 0; k < 118; k++) enqueue(random_cmd());
            enqueue(mk(FN_TICK, .delta(24'hFFFFFF)));
            wait_idle();
        end

        $display("Covered %0d appearance settings: %0d spawns, %0d pool-full refusals,",
                 n_phases, n_spawn, n_full);
        $display("%0d ticks, %0d live reads and %0d dead reads.", n_tick, n_live_rd, n_dead_rd);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
design/pp_pkg.sv
design/pp_store.sv
design/pp_free.sv
design/pp_mac.sv
design/pp_div.sv
design/particle_pool_engine.sv
design/pp_chk.sv
dv/particle_pool_engine_tb.sv
